>>> sv/tpmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmts_pkg
// Shared types and constants of the melody tone sequencer: the fixed tune,
// the divider constants, action codes and the digit-serial geometry.
// ----------------------------------------------------------------------------
package tpmts_pkg;

  localparam int TICK_W     = 64;
  localparam int DIGIT_W    = 2;
  localparam int NUM_DIGITS = TICK_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int LEN_W      = 8;
  localparam int FREQ_W     = 16;
  localparam int POS_W      = 6;
  localparam int QUOT_W     = 21;
  localparam int QCNT_W     = $clog2(QUOT_W);

  localparam logic [QUOT_W-1:0] BASE_CLOCK_HZ = 21'd1193182;
  localparam logic [FREQ_W-1:0] DIV_MAX       = 16'hFFFF;
  localparam logic [FREQ_W-1:0] DIV_MIN       = 16'd2;

  localparam logic [LEN_W-1:0] NOTE_TICKS_RESET = 8'd11;
  localparam logic [LEN_W-1:0] GAP_TICKS_RESET  = 8'd1;

  localparam logic REG_NOTE_TICKS = 1'b0;
  localparam logic REG_GAP_TICKS  = 1'b1;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TONE    = 2'd1;
  localparam logic [1:0] ACT_SILENCE = 2'd2;

  localparam logic [FREQ_W-1:0] TUNE [64] = '{
    16'd622,  16'd659,  16'd740,  16'd988,  16'd622,  16'd659,  16'd740,  16'd988,
    16'd1109, 16'd1245, 16'd1109, 16'd932,  16'd988,  16'd1109, 16'd988,  16'd740,
    16'd740,  16'd831,  16'd988,  16'd740,  16'd831,  16'd988,  16'd1109, 16'd1245,
    16'd988,  16'd1319, 16'd1245, 16'd1319, 16'd1480, 16'd988,  16'd932,  16'd988,
    16'd494,  16'd740,  16'd831,  16'd988,  16'd740,  16'd988,  16'd1109, 16'd1245,
    16'd1109, 16'd932,  16'd988,  16'd740,  16'd622,  16'd740,  16'd494,  16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0
  };

  typedef struct packed {
    logic                start;
    logic [FREQ_W-1:0]   hz;
  } div_req_t;

endpackage

>>> sv/tick_paced_melody_tone_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_paced_melody_tone_sequencer
// One item at a time: in_stall holds off a new input until the block is idle
// again. The 64-bit deadline compare and saturating add run 2 bits per cycle;
// the bit-serial divider runs alongside. An output stall holds the block
// until the result register frees up; a new input is taken while a previous
// result still waits.
// Reset (sync, active low): note 0 next, deadline 0, in gap, speaker off.
// ----------------------------------------------------------------------------
module tick_paced_melody_tone_sequencer
  import tpmts_pkg::*;
#(
  parameter int TABLE_LENGTH = 48
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TICK_W-1:0] in_tick_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_action,
  output logic [FREQ_W-1:0] out_divisor,
  output logic              out_speaker_on
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  localparam logic [POS_W:0] TLEN = (POS_W + 1)'(TABLE_LENGTH);

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TICK_W-1:0]   now_sr_r;
  logic [TICK_W-1:0]   dl_r;
  logic [TICK_W-1:0]   sum_sr_r;
  logic [LEN_W-1:0]    len_sr_r;
  logic                carry_r;
  logic                ge_r;
  logic                gap_r;
  logic                sounding_r;
  logic                hz_zero_r;
  logic [POS_W-1:0]    pos_r;
  logic [LEN_W-1:0]    note_ticks_r;
  logic [LEN_W-1:0]    gap_ticks_r;
  logic                out_valid_r;
  logic [1:0]          out_action_r;
  logic [FREQ_W-1:0]   out_divisor_r;
  logic                out_speaker_on_r;

  logic                accept;
  logic [POS_W-1:0]    pos_eff;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    pos_nxt;
  logic [FREQ_W-1:0]   hz;
  logic [DIGIT_W-1:0]  dig_a;
  logic [DIGIT_W-1:0]  dig_b;
  logic [DIGIT_W:0]    dig_sum;
  logic                ge_nxt;
  logic                out_free;
  logic [1:0]          out_action_nxt;
  logic [FREQ_W-1:0]   out_divisor_nxt;
  logic                out_speaker_on_nxt;
  div_req_t            div_req;
  logic [FREQ_W-1:0]   divisor;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign pos_eff = ((POS_W + 1)'(pos_r) >= TLEN) ? '0 : pos_r;
  assign pos_inc = (POS_W + 1)'(pos_eff) + 1'b1;
  assign pos_nxt = (pos_inc >= TLEN) ? '0 : pos_inc[POS_W-1:0];
  assign hz      = TUNE[pos_eff];

  assign dig_a   = now_sr_r[DIGIT_W-1:0];
  assign dig_b   = dl_r[DIGIT_W-1:0];
  assign dig_sum = (DIGIT_W + 1)'(dig_a) + (DIGIT_W + 1)'(len_sr_r[DIGIT_W-1:0])
                 + (DIGIT_W + 1)'(carry_r);

  always_comb begin
    if (dig_a[1] != dig_b[1]) begin
      ge_nxt = dig_a[1];
    end else if (dig_a[0] != dig_b[0]) begin
      ge_nxt = dig_a[0];
    end else begin
      ge_nxt = ge_r;
    end
  end

  always_comb begin
    out_action_nxt     = ACT_NONE;
    out_divisor_nxt    = '0;
    out_speaker_on_nxt = sounding_r;
    if (ge_r) begin
      if (!gap_r) begin
        out_action_nxt     = ACT_SILENCE;
        out_speaker_on_nxt = 1'b0;
      end else if (hz_zero_r) begin
        out_action_nxt     = ACT_SILENCE;
        out_speaker_on_nxt = 1'b0;
      end else begin
        out_action_nxt     = ACT_TONE;
        out_divisor_nxt    = divisor;
        out_speaker_on_nxt = 1'b1;
      end
    end
  end

  assign div_req.start = accept;
  assign div_req.hz    = hz;

  tpmts_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (divisor)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_ticks_r <= NOTE_TICKS_RESET;
      gap_ticks_r  <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOTE_TICKS: note_ticks_r <= cfg_wdata;
        REG_GAP_TICKS:  gap_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dl_r        <= '0;
      gap_r       <= 1'b1;
      sounding_r  <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            now_sr_r  <= in_tick_count;
            len_sr_r  <= gap_r ? note_ticks_r : gap_ticks_r;
            carry_r   <= 1'b0;
            ge_r      <= 1'b1;
            cnt_r     <= '0;
            hz_zero_r <= (hz == '0);
            state_r   <= S_RUN;
          end
        end
        S_RUN: begin
          now_sr_r <= {DIGIT_W'(0), now_sr_r[TICK_W-1:DIGIT_W]};
          dl_r     <= {dl_r[DIGIT_W-1:0], dl_r[TICK_W-1:DIGIT_W]};
          sum_sr_r <= {dig_sum[DIGIT_W-1:0], sum_sr_r[TICK_W-1:DIGIT_W]};
          len_sr_r <= {DIGIT_W'(0), len_sr_r[LEN_W-1:DIGIT_W]};
          carry_r  <= dig_sum[DIGIT_W];
          ge_r     <= ge_nxt;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_DIGITS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_action_r     <= out_action_nxt;
            out_divisor_r    <= out_divisor_nxt;
            out_speaker_on_r <= out_speaker_on_nxt;
            sounding_r       <= out_speaker_on_nxt;
            if (ge_r) begin
              dl_r  <= carry_r ? '1 : sum_sr_r;
              gap_r <= !gap_r;
              if (gap_r) begin
                pos_r <= pos_nxt;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_divisor    = out_divisor_r;
  assign out_speaker_on = out_speaker_on_r;

endmodule

>>> sv/tpmts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmts_div
// Bit-serial restoring divider: base clock over note frequency, one quotient
// bit per cycle, result clamped to the valid timer divisor range.
// ----------------------------------------------------------------------------
module tpmts_div
  import tpmts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic [FREQ_W-1:0] divisor
);

  logic                run_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [FREQ_W-1:0]   hz_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [QUOT_W-1:0]   quo_r;

  logic [FREQ_W:0]     trial;
  logic                fits;
  logic [FREQ_W-1:0]   rem_nxt;

  assign trial   = {rem_r, BASE_CLOCK_HZ[cnt_r]};
  assign fits    = trial >= {1'b0, hz_r};
  assign rem_nxt = fits ? FREQ_W'(trial - {1'b0, hz_r}) : trial[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= QCNT_W'(QUOT_W - 1);
      hz_r  <= req.hz;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUOT_W-2:0], fits};
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_comb begin
    if (quo_r > QUOT_W'(DIV_MAX)) begin
      divisor = DIV_MAX;
    end else if (quo_r < QUOT_W'(DIV_MIN)) begin
      divisor = DIV_MIN;
    end else begin
      divisor = quo_r[FREQ_W-1:0];
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick transactions into the melody tone sequencer and checks every
// result against a cycle-free model of the note/gap sequencing (typed rows:
// their own want). It starts with a table of directed ticks, then runs random
// phases at several note/gap lengths; both sides idle at random in phases 0-3.
// ----------------------------------------------------------------------------
module testbench;
  import tpmts_pkg::*;

  localparam int TUNE_LEN   = 48;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_LEN  = 200;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [1:0]        action;
    logic [FREQ_W-1:0] divisor;
    logic              speaker_on;
  } melody_out_t;

  typedef struct packed {
    logic              load;
    logic [LEN_W-1:0]  note_len;
    logic [LEN_W-1:0]  gap_len;
    logic [TICK_W-1:0] tick;
    logic              typed;
    melody_out_t       want;
  } tick_row_t;

  localparam melody_out_t NO_OUT = '{ACT_NONE, 16'd0, 1'b0};

  localparam tick_row_t DIRECTED [21] = '{
    '{1'b0, 8'd0,   8'd0,   64'd0,      1'b1, '{ACT_TONE,    16'd1918, 1'b1}},
    '{1'b0, 8'd0,   8'd0,   64'd5,      1'b1, '{ACT_NONE,    16'd0,    1'b1}},
    '{1'b0, 8'd0,   8'd0,   64'd11,     1'b1, '{ACT_SILENCE, 16'd0,    1'b0}},
    '{1'b0, 8'd0,   8'd0,   64'd3,      1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd12,     1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd12,     1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd23,     1'b0, NO_OUT},
    '{1'b1, 8'd0,   8'd0,   64'd100,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd100,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd100,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd100,    1'b0, NO_OUT},
    '{1'b1, 8'd255, 8'd255, 64'd200,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd454,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd455,    1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   64'd710,    1'b0, NO_OUT},
    '{1'b1, 8'd11,  8'd1,   64'hFFFF_FFFF_FFFF_FF00, 1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   TICK_MAX,   1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   TICK_MAX,   1'b1, '{ACT_SILENCE, 16'd0,    1'b0}},
    '{1'b0, 8'd0,   8'd0,   64'd0,      1'b1, '{ACT_NONE,    16'd0,    1'b0}},
    '{1'b0, 8'd0,   8'd0,   TICK_MAX,   1'b0, NO_OUT},
    '{1'b0, 8'd0,   8'd0,   TICK_MAX,   1'b1, '{ACT_SILENCE, 16'd0,    1'b0}}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [LEN_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [TICK_W-1:0] in_tick_count;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_action;
  logic [FREQ_W-1:0] out_divisor;
  logic              out_speaker_on;

  logic [LEN_W-1:0]  cur_note_len;
  logic [LEN_W-1:0]  cur_gap_len;
  logic [POS_W-1:0]  play_pos;
  logic [TICK_W-1:0] next_deadline;
  logic              between_notes;
  logic              speaker_state;
  logic [TICK_W-1:0] last_tick;

  melody_out_t pending_actions [$];
  melody_out_t oldest;
  int          error_count = 0;
  int          sender_pct = 38;
  int          receiver_pct = 46;

  tick_paced_melody_tone_sequencer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tick_count  (in_tick_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_divisor    (out_divisor),
    .out_speaker_on (out_speaker_on)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic melody_out_t advance_melody(input logic [TICK_W-1:0] now);
    melody_out_t       r;
    logic [FREQ_W-1:0] hz;
    logic [31:0]       quot;
    logic [TICK_W:0]   sum;
    r = NO_OUT;
    if (now >= next_deadline) begin
      if (between_notes) begin
        if (play_pos >= TUNE_LEN) play_pos = '0;
        hz = TUNE[play_pos];
        play_pos = (play_pos + 1 >= TUNE_LEN) ? '0 : play_pos + 1'b1;
        if (hz == '0) begin
          r.action = ACT_SILENCE;
          speaker_state = 1'b0;
        end else begin
          quot = 32'(BASE_CLOCK_HZ) / 32'(hz);
          if (quot > 32'(DIV_MAX)) quot = 32'(DIV_MAX);
          if (quot < 32'(DIV_MIN)) quot = 32'(DIV_MIN);
          r.action = ACT_TONE;
          r.divisor = quot[FREQ_W-1:0];
          speaker_state = 1'b1;
        end
        between_notes = 1'b0;
        sum = {1'b0, now} + (TICK_W + 1)'(cur_note_len);
      end else begin
        r.action = ACT_SILENCE;
        speaker_state = 1'b0;
        between_notes = 1'b1;
        sum = {1'b0, now} + (TICK_W + 1)'(cur_gap_len);
      end
      next_deadline = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
    end
    r.speaker_on = speaker_state;
    return r;
  endfunction

  // Call right after a rising edge; returns right after the accepting edge.
  task automatic send_tick(input logic [TICK_W-1:0] t, input logic typed,
                           input melody_out_t want);
    int          idle;
    melody_out_t predicted;
    idle = 0;
    while ($urandom_range(99) < sender_pct) idle++;
    if (sender_pct != 0 && $urandom_range(99) < 3) idle += $urandom_range(1, 40);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_tick_count <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_melody(t);
    last_tick = t;
    pending_actions.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_actions.size() != 0);
  endtask

  task automatic load_lengths(input logic [LEN_W-1:0] note_len,
                              input logic [LEN_W-1:0] gap_len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NOTE_TICKS;
    cfg_wdata <= note_len;
    @(posedge clk);
    cur_note_len = note_len;
    cfg_index <= REG_GAP_TICKS;
    cfg_wdata <= gap_len;
    @(posedge clk);
    cur_gap_len = gap_len;
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < receiver_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected result action=%0d divisor=%0d speaker_on=%0b",
                 $time, out_action, out_divisor, out_speaker_on);
        error_count++;
      end else begin
        oldest = pending_actions.pop_front();
        if (out_action !== oldest.action) begin
          $display("%0t: action mismatch, expected %0d actual %0d",
                   $time, oldest.action, out_action);
          error_count++;
        end
        if (out_divisor !== oldest.divisor) begin
          $display("%0t: divisor mismatch, expected %0d actual %0d",
                   $time, oldest.divisor, out_divisor);
          error_count++;
        end
        if (out_speaker_on !== oldest.speaker_on) begin
          $display("%0t: speaker_on mismatch, expected %0b actual %0b",
                   $time, oldest.speaker_on, out_speaker_on);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [TICK_W-1:0] stim_tick;
    logic [LEN_W-1:0]  phase_note;
    logic [LEN_W-1:0]  phase_gap;
    int                pick;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_NOTE_TICKS;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_tick_count <= '0;
    cur_note_len  = NOTE_TICKS_RESET;
    cur_gap_len   = GAP_TICKS_RESET;
    play_pos      = '0;
    next_deadline = '0;
    between_notes = 1'b1;
    speaker_state = 1'b0;
    last_tick     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].load) begin
        drain_results();
        load_lengths(DIRECTED[i].note_len, DIRECTED[i].gap_len);
      end
      send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin phase_note = 8'd1;   phase_gap = 8'd0;   end
        1: begin phase_note = 8'd255; phase_gap = 8'd255; end
        2: begin phase_note = 8'd0;   phase_gap = 8'd0;   end
        3: begin
          phase_note = 8'($urandom_range(255));
          phase_gap  = 8'($urandom_range(255));
        end
        4: begin
          phase_note = 8'($urandom_range(1, 6));
          phase_gap  = 8'($urandom_range(0, 3));
        end
        default: begin phase_note = NOTE_TICKS_RESET; phase_gap = GAP_TICKS_RESET; end
      endcase
      sender_pct   = (phase < 2) ? 38 : (phase < 4) ? 46 : 0;
      receiver_pct = (phase < 2) ? 46 : (phase < 4) ? 38 : 0;
      drain_results();
      load_lengths(phase_note, phase_gap);
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = int'($urandom_range(99));
        if (pick < 40)      stim_tick = next_deadline;
        else if (pick < 55) stim_tick = next_deadline - 1'b1;
        else if (pick < 75) stim_tick = last_tick + $urandom_range(0, 3);
        else if (pick < 85) stim_tick = last_tick;
        else if (pick < 92) stim_tick = {$urandom, $urandom};
        else                stim_tick = last_tick - $urandom_range(0, 300);
        send_tick(stim_tick, 1'b0, NO_OUT);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/tpmts_pkg.sv
sv/tpmts_div.sv
sv/tick_paced_melody_tone_sequencer.sv
verif/testbench.sv
